// ----- rtl/qfs_pkg.sv -----
// ---------------------------------------------------------------------------
// qfs_pkg: shared definitions for the quantized frame statistics block
// Field widths, register indexes, reset values and the control bundles that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package qfs_pkg;

    localparam int RAW_W       = 10;
    localparam int Q_W         = 16;
    localparam int IDX_W       = 10;
    localparam int RMS_W       = 15;
    localparam int FRAME_NUM_W = 32;
    localparam int FLEN_W      = 11;
    localparam int RES_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = FLEN_W;

    localparam int MAX_FRAME_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATS  = 1'b1;

    localparam logic [FLEN_W-1:0] FRAME_LEN_RST  = 11'd128;
    localparam logic [RES_W-1:0]  RESOLUTION_RST = 4'd4;
    localparam logic [RES_W-1:0]  RES_MIN        = 4'd1;
    localparam logic [RES_W-1:0]  RES_MAX        = 4'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic root_start;
        logic root_step;
        logic load_stats;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic frame_end;
        logic div_last;
        logic root_last;
    } t_status;

endpackage

// ----- rtl/qfs_ctrl.sv -----
// ---------------------------------------------------------------------------
// qfs_ctrl: sequencing state machine
// Walks each beat through capture, accumulation and delivery, and at the end
// of a frame through the divide, the square root and the statistics beat.
// ---------------------------------------------------------------------------
module qfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  qfs_pkg::t_status i_status,
    output qfs_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import qfs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_ACC       = 8'b0000_0010,
        S_OUT_SMP   = 8'b0000_0100,
        S_DIV       = 8'b0000_1000,
        S_ROOT_INIT = 8'b0001_0000,
        S_ROOT      = 8'b0010_0000,
        S_LOAD      = 8'b0100_0000,
        S_OUT_STAT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state          = S_OUT_SMP;
            end
            S_OUT_SMP: begin
                if (!i_out_stall) begin
                    if (i_status.frame_end) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_ROOT_INIT;
                end
            end
            S_ROOT_INIT: begin
                o_cmd.root_start = 1'b1;
                n_state          = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_stats = 1'b1;
                n_state          = S_OUT_STAT;
            end
            S_OUT_STAT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT_SMP) || (r_state == S_OUT_STAT);

endmodule

// ----- rtl/qfs_datapath.sv -----
// ---------------------------------------------------------------------------
// qfs_datapath: requantizer, frame accumulators, divider and square root
// Holds the configuration, the running extremes and square sum, a restoring
// divider and a digit-by-digit square root, and the result register.
// ---------------------------------------------------------------------------
module qfs_datapath #(
    parameter int MAX_FRAME = qfs_pkg::MAX_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qfs_pkg::t_cmd                       i_cmd,
    output qfs_pkg::t_status                    o_status,
    input  logic                                i_cfg_we,
    input  logic [qfs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qfs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [qfs_pkg::RAW_W-1:0]           i_raw_sample,
    output logic                                o_kind,
    output logic signed [qfs_pkg::Q_W-1:0]      o_quant_sample,
    output logic [qfs_pkg::FRAME_NUM_W-1:0]     o_frame_number,
    output logic signed [qfs_pkg::Q_W-1:0]      o_peak_value,
    output logic [qfs_pkg::IDX_W-1:0]           o_peak_index,
    output logic signed [qfs_pkg::Q_W-1:0]      o_trough_value,
    output logic [qfs_pkg::IDX_W-1:0]           o_trough_index,
    output logic [qfs_pkg::RMS_W-1:0]           o_rms_value,
    output logic                                o_last
);
    import qfs_pkg::*;

    localparam int POS_W  = $clog2(MAX_FRAME);
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SQ_W   = 2 * Q_W;
    localparam int SUM_W  = 2 * Q_W - 1 + POS_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int RAD_W  = 2 * RMS_W;
    localparam int REM_W  = RMS_W + 3;

    // Configuration.
    logic [FLEN_W-1:0] r_frame_len;
    logic [RES_W-1:0]  r_resolution;

    // Frame state.
    logic signed [Q_W-1:0] r_q, n_q;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic signed [Q_W-1:0] r_max, n_max;
    logic [POS_W-1:0]      r_max_pos, n_max_pos;
    logic signed [Q_W-1:0] r_min, n_min;
    logic [POS_W-1:0]      r_min_pos, n_min_pos;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_frame_end, n_frame_end;
    logic [FRAME_NUM_W-1:0] r_frames, n_frames;

    // Divider and square root.
    logic [SUM_W-1:0]  r_dq, n_dq;
    logic [CNT_W-1:0]  r_dr, n_dr;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [RMS_W-1:0]  r_root, n_root;
    logic [STEP_W-1:0] r_step, n_step;

    // Result register.
    logic                   n_kind, n_last;
    logic signed [Q_W-1:0]  n_quant_sample, n_peak_value, n_trough_value;
    logic [FRAME_NUM_W-1:0] n_frame_number;
    logic [IDX_W-1:0]       n_peak_index, n_trough_index;
    logic [RMS_W-1:0]       n_rms_value;

    logic [RES_W-1:0]       res_b;
    logic [RES_W-1:0]       shift_s;
    logic [RAW_W-1:0]       centered;
    logic [RAW_W-1:0]       keep_mask;
    logic [CNT_W-1:0]       len;
    logic [CNT_W-1:0]       count;
    logic signed [SQ_W-1:0] square;
    logic [CNT_W:0]         div_trial;
    logic [RMS_W-1:0]       mean_sat;
    logic [REM_W-1:0]       root_rem;
    logic [REM_W-1:0]       root_trial;

    always_comb begin
        if (r_resolution < RES_MIN) begin
            res_b = RES_MIN;
        end else if (r_resolution > RES_MAX) begin
            res_b = RES_MAX;
        end else begin
            res_b = r_resolution;
        end
        shift_s = RES_MAX - res_b;
        // Flipping the top bit gives raw minus midscale in two's complement.
        // Clearing the low bits is a floor division, and the fixed six-bit
        // shift places the kept bits at the top of the Q15 word.
        centered  = {~i_raw_sample[RAW_W-1], i_raw_sample[RAW_W-2:0]};
        keep_mask = {RAW_W{1'b1}} << shift_s;

        if (r_frame_len == '0) begin
            len = CNT_W'(1);
        end else if (32'(r_frame_len) > MAX_FRAME) begin
            len = CNT_W'(MAX_FRAME);
        end else begin
            len = CNT_W'(r_frame_len);
        end
        count  = CNT_W'(r_pos) + CNT_W'(1);
        square = r_q * r_q;

        div_trial = {r_dr, r_dq[SUM_W-1]};

        if (|r_dq[SUM_W-1:2*RMS_W]) begin
            mean_sat = {RMS_W{1'b1}};
        end else begin
            mean_sat = r_dq[2*RMS_W-1:RMS_W];
        end

        root_rem   = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
        root_trial = {1'b0, r_root, 2'b01};
    end

    always_comb begin
        n_q         = r_q;
        n_pos       = r_pos;
        n_max       = r_max;
        n_max_pos   = r_max_pos;
        n_min       = r_min;
        n_min_pos   = r_min_pos;
        n_sum       = r_sum;
        n_count     = r_count;
        n_frame_end = r_frame_end;
        n_frames    = r_frames;
        n_dq        = r_dq;
        n_dr        = r_dr;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_step      = r_step;

        n_kind         = o_kind;
        n_quant_sample = o_quant_sample;
        n_frame_number = o_frame_number;
        n_peak_value   = o_peak_value;
        n_peak_index   = o_peak_index;
        n_trough_value = o_trough_value;
        n_trough_index = o_trough_index;
        n_rms_value    = o_rms_value;
        n_last         = o_last;

        if (i_cmd.capture) begin
            n_q = $signed({centered & keep_mask, 6'b000000});
        end

        if (i_cmd.accumulate) begin
            if (r_pos == '0) begin
                n_max     = r_q;
                n_max_pos = '0;
                n_min     = r_q;
                n_min_pos = '0;
                n_sum     = SUM_W'($unsigned(square));
            end else begin
                if (r_q > r_max) begin
                    n_max     = r_q;
                    n_max_pos = r_pos;
                end
                if (r_q < r_min) begin
                    n_min     = r_q;
                    n_min_pos = r_pos;
                end
                n_sum = r_sum + SUM_W'($unsigned(square));
            end
            n_count     = count;
            n_frame_end = (count >= len);
            if (count >= len) begin
                n_pos = '0;
            end else begin
                n_pos = POS_W'(count);
            end

            n_kind         = KIND_SAMPLE;
            n_quant_sample = r_q;
            n_frame_number = '0;
            n_peak_value   = '0;
            n_peak_index   = '0;
            n_trough_value = '0;
            n_trough_index = '0;
            n_rms_value    = '0;
            n_last         = !(count >= len);
        end

        if (i_cmd.div_start) begin
            n_dq   = r_sum;
            n_dr   = '0;
            n_step = '0;
        end

        // Restoring division: one quotient bit per step of the step counter.
        if (i_cmd.div_step) begin
            if (div_trial >= {1'b0, r_count}) begin
                n_dr = CNT_W'(div_trial - {1'b0, r_count});
                n_dq = {r_dq[SUM_W-2:0], 1'b1};
            end else begin
                n_dr = CNT_W'(div_trial);
                n_dq = {r_dq[SUM_W-2:0], 1'b0};
            end
            n_step = r_step + STEP_W'(1);
        end

        if (i_cmd.root_start) begin
            n_rad  = {mean_sat, {RMS_W{1'b0}}};
            n_rem  = '0;
            n_root = '0;
            n_step = '0;
        end

        // Square root, two radicand bits per step.
        if (i_cmd.root_step) begin
            if (root_rem >= root_trial) begin
                n_rem  = root_rem - root_trial;
                n_root = {r_root[RMS_W-2:0], 1'b1};
            end else begin
                n_rem  = root_rem;
                n_root = {r_root[RMS_W-2:0], 1'b0};
            end
            n_rad  = {r_rad[RAD_W-3:0], 2'b00};
            n_step = r_step + STEP_W'(1);
        end

        if (i_cmd.load_stats) begin
            n_frames       = r_frames + FRAME_NUM_W'(1);
            n_kind         = KIND_STATS;
            n_quant_sample = '0;
            n_frame_number = r_frames + FRAME_NUM_W'(1);
            n_peak_value   = r_max;
            n_peak_index   = IDX_W'(r_max_pos);
            n_trough_value = r_min;
            n_trough_index = IDX_W'(r_min_pos);
            n_rms_value    = r_root;
            n_last         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len  <= FRAME_LEN_RST;
            r_resolution <= RESOLUTION_RST;
            r_pos        <= '0;
            r_frames     <= '0;
            r_frame_end  <= 1'b0;
            r_step       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_LEN:  r_frame_len  <= i_cfg_data;
                    CFG_RESOLUTION: r_resolution <= i_cfg_data[RES_W-1:0];
                    default: ;
                endcase
            end
            r_pos       <= n_pos;
            r_frames    <= n_frames;
            r_frame_end <= n_frame_end;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q            <= n_q;
        r_max          <= n_max;
        r_max_pos      <= n_max_pos;
        r_min          <= n_min;
        r_min_pos      <= n_min_pos;
        r_sum          <= n_sum;
        r_count        <= n_count;
        r_dq           <= n_dq;
        r_dr           <= n_dr;
        r_rad          <= n_rad;
        r_rem          <= n_rem;
        r_root         <= n_root;
        o_kind         <= n_kind;
        o_quant_sample <= n_quant_sample;
        o_frame_number <= n_frame_number;
        o_peak_value   <= n_peak_value;
        o_peak_index   <= n_peak_index;
        o_trough_value <= n_trough_value;
        o_trough_index <= n_trough_index;
        o_rms_value    <= n_rms_value;
        o_last         <= n_last;
    end

    assign o_status.frame_end = r_frame_end;
    assign o_status.div_last  = (r_step == STEP_W'(SUM_W - 1));
    assign o_status.root_last = (r_step == STEP_W'(RMS_W - 1));

endmodule

// ----- rtl/quantized_frame_statistics.sv -----
// A sample's result passes through the requantized sample register and the
// result register; the block takes no new sample until the last one's beat
// has been delivered. After a frame's last sample, the one-bit-per-cycle
// divider and the 15-step square root run before the statistics beat. Reset
// is synchronous and active low; it restores default configuration and
// clears the frame position and frame count.
// ---------------------------------------------------------------------------
// quantized_frame_statistics: Q15 requantizer with per-frame statistics
// Emits every requantized sample and, at the end of each frame, the maximum,
// minimum, their first positions and the RMS of the frame.
// ---------------------------------------------------------------------------
module quantized_frame_statistics #(
    parameter int MAX_FRAME = qfs_pkg::MAX_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [qfs_pkg::RAW_W-1:0]           i_raw_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_kind,
    output logic signed [qfs_pkg::Q_W-1:0]      o_quant_sample,
    output logic [qfs_pkg::FRAME_NUM_W-1:0]     o_frame_number,
    output logic signed [qfs_pkg::Q_W-1:0]      o_peak_value,
    output logic [qfs_pkg::IDX_W-1:0]           o_peak_index,
    output logic signed [qfs_pkg::Q_W-1:0]      o_trough_value,
    output logic [qfs_pkg::IDX_W-1:0]           o_trough_index,
    output logic [qfs_pkg::RMS_W-1:0]           o_rms_value,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qfs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qfs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import qfs_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    qfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (o_valid)
    );

    qfs_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_raw_sample   (i_raw_sample),
        .o_kind         (o_kind),
        .o_quant_sample (o_quant_sample),
        .o_frame_number (o_frame_number),
        .o_peak_value   (o_peak_value),
        .o_peak_index   (o_peak_index),
        .o_trough_value (o_trough_value),
        .o_trough_index (o_trough_index),
        .o_rms_value    (o_rms_value),
        .o_last         (o_last)
    );

    assign o_stall     = !in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- tb/tb_quantized_frame_statistics.sv -----
// ---------------------------------------------------------------------------
// tb_quantized_frame_statistics: self-checking bench for the frame statistics
// Drives raw converter samples and register writes, predicts every sample
// beat and end-of-frame beat in a tracker class, and compares each output
// beat field by field under random sender and receiver stalls.
// ---------------------------------------------------------------------------
module tb_quantized_frame_statistics;
    import qfs_pkg::*;

    typedef struct {
        logic                         kind;
        logic signed [Q_W-1:0]        quant_sample;
        logic [FRAME_NUM_W-1:0]       frame_number;
        logic signed [Q_W-1:0]        peak_value;
        logic [IDX_W-1:0]             peak_index;
        logic signed [Q_W-1:0]        trough_value;
        logic [IDX_W-1:0]             trough_index;
        logic [RMS_W-1:0]             rms_value;
        logic                         last;
    } t_stats_beat;

    class frame_stats_tracker;
        logic [FLEN_W-1:0]      frame_len;
        logic [RES_W-1:0]       res_bits;
        int unsigned            position;
        int                     peak;
        int unsigned            peak_pos;
        int                     trough;
        int unsigned            trough_pos;
        longint unsigned        square_sum;
        logic [FRAME_NUM_W-1:0] frames_done;
        t_stats_beat            awaited_beats[$];
        int                     errors;

        function new();
            frame_len   = FRAME_LEN_RST;
            res_bits    = RESOLUTION_RST;
            position    = 0;
            peak        = 0;
            peak_pos    = 0;
            trough      = 0;
            trough_pos  = 0;
            square_sum  = 0;
            frames_done = '0;
            errors      = 0;
        endfunction

        function int unsigned root_floor(longint unsigned v);
            int unsigned root;
            int unsigned trial;
            root = 0;
            for (int k = 15; k >= 0; k--) begin
                trial = root | (32'd1 << k);
                if (longint'(trial) * longint'(trial) <= v)
                    root = trial;
            end
            return root;
        endfunction

        function void note_sample(logic [RAW_W-1:0] raw);
            int unsigned     bits;
            int unsigned     len;
            int unsigned     count;
            int              centered;
            int              q;
            longint unsigned mean_sq;
            t_stats_beat     beat;

            bits = res_bits;
            if (bits < RES_MIN) bits = RES_MIN;
            if (bits > RES_MAX) bits = RES_MAX;
            // Arithmetic shift of the centered value gives the floor division.
            centered = int'(raw) - 512;
            q = (centered >>> (RAW_W - bits)) * (1 << (Q_W - bits));

            len = frame_len;
            if (len < 1) len = 1;
            if (len > MAX_FRAME_DEF) len = MAX_FRAME_DEF;

            if (position == 0) begin
                peak       = q;
                peak_pos   = 0;
                trough     = q;
                trough_pos = 0;
                square_sum = 0;
            end else begin
                if (q > peak) begin
                    peak     = q;
                    peak_pos = position;
                end
                if (q < trough) begin
                    trough     = q;
                    trough_pos = position;
                end
            end
            square_sum += longint'(q) * longint'(q);

            beat              = '{default: '0};
            beat.kind         = KIND_SAMPLE;
            beat.quant_sample = Q_W'(q);
            count = position + 1;
            if (count < len) begin
                position  = count;
                beat.last = 1'b1;
                awaited_beats.push_back(beat);
                return;
            end
            awaited_beats.push_back(beat);

            // A frame cut short by a lowered length divides by the samples taken.
            mean_sq = (square_sum / count) >> 15;
            if (mean_sq > 32767) mean_sq = 32767;
            frames_done++;
            beat              = '{default: '0};
            beat.kind         = KIND_STATS;
            beat.frame_number = frames_done;
            beat.peak_value   = Q_W'(peak);
            beat.peak_index   = IDX_W'(peak_pos);
            beat.trough_value = Q_W'(trough);
            beat.trough_index = IDX_W'(trough_pos);
            beat.rms_value    = RMS_W'(root_floor(mean_sq << 15));
            beat.last         = 1'b1;
            awaited_beats.push_back(beat);

            position   = 0;
            peak       = 0;
            peak_pos   = 0;
            trough     = 0;
            trough_pos = 0;
            square_sum = 0;
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(t_stats_beat got);
            t_stats_beat want;
            if (awaited_beats.size() == 0) begin
                $error("output beat with nothing awaited: kind %0d", got.kind);
                errors++;
                return;
            end
            want = awaited_beats.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("quant_sample", want.quant_sample, got.quant_sample);
            compare_field("frame_number", want.frame_number, got.frame_number);
            compare_field("peak_value", want.peak_value, got.peak_value);
            compare_field("peak_index", want.peak_index, got.peak_index);
            compare_field("trough_value", want.trough_value, got.trough_value);
            compare_field("trough_index", want.trough_index, got.trough_index);
            compare_field("rms_value", want.rms_value, got.rms_value);
            compare_field("last", want.last, got.last);
        endfunction

        function void check_drained();
            if (awaited_beats.size() != 0) begin
                $error("%0d output beats never arrived", awaited_beats.size());
                errors += awaited_beats.size();
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [RAW_W-1:0]           i_raw_sample;
    logic                       o_valid;
    logic                       i_stall;
    logic                       o_kind;
    logic signed [Q_W-1:0]      o_quant_sample;
    logic [FRAME_NUM_W-1:0]     o_frame_number;
    logic signed [Q_W-1:0]      o_peak_value;
    logic [IDX_W-1:0]           o_peak_index;
    logic signed [Q_W-1:0]      o_trough_value;
    logic [IDX_W-1:0]           o_trough_index;
    logic [RMS_W-1:0]           o_rms_value;
    logic                       o_last;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    frame_stats_tracker tracker = new();
    int                 send_idle_pct;
    int                 recv_idle_pct;

    quantized_frame_statistics uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_raw_sample   (i_raw_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_quant_sample (o_quant_sample),
        .o_frame_number (o_frame_number),
        .o_peak_value   (o_peak_value),
        .o_peak_index   (o_peak_index),
        .o_trough_value (o_trough_value),
        .o_trough_index (o_trough_index),
        .o_rms_value    (o_rms_value),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: checks each accepted beat and stalls at random.
    initial begin
        t_stats_beat got;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.kind         = o_kind;
                got.quant_sample = o_quant_sample;
                got.frame_number = o_frame_number;
                got.peak_value   = o_peak_value;
                got.peak_index   = o_peak_index;
                got.trough_value = o_trough_value;
                got.trough_index = o_trough_index;
                got.rms_value    = o_rms_value;
                got.last         = o_last;
                tracker.check_beat(got);
            end
            @(negedge i_clk);
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic push_sample(input logic [RAW_W-1:0] raw);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_raw_sample <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_sample(raw);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (tracker.awaited_beats.size() != 0) @(negedge i_clk);
    endtask

    // Writes both registers once the block has drained.
    task automatic configure(input logic [FLEN_W-1:0] flen, input logic [RES_W-1:0] res);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FRAME_LEN;
        i_cfg_data  <= flen;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.frame_len = flen;
        @(negedge i_clk);
        i_cfg_index <= CFG_RESOLUTION;
        i_cfg_data  <= CFG_DATA_W'(res);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.res_bits = res;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RAW_W'(511 + $urandom_range(0, 1));
            default: return RAW_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [FLEN_W-1:0] pick_frame_len();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return FLEN_W'(MAX_FRAME_DEF);
            2: return '1;
            3: return FLEN_W'($urandom_range(0, 2047));
            default: return FLEN_W'($urandom_range(1, 16));
        endcase
    endfunction

    initial begin
        int idle_send[3];
        int idle_recv[3];

        idle_send = '{10, 82, 0};
        idle_recv = '{82, 10, 0};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_raw_sample = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_FRAME_LEN;
        i_cfg_data   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings, then a length lowered below the running count.
        push_sample(10'd512);
        push_sample(10'd0);
        push_sample(10'd1023);
        configure(11'd1, 4'd4);
        push_sample(10'd511);

        // Zero length and zero resolution act as one.
        configure(11'd0, 4'd0);
        push_sample(10'd0);
        push_sample(10'd1023);
        push_sample(10'd512);
        push_sample(10'd511);

        // One kept bit makes many ties; the earliest position must win.
        configure(11'd5, 4'd1);
        push_sample(10'd600);
        push_sample(10'd1023);
        push_sample(10'd0);
        push_sample(10'd700);
        push_sample(10'd1);

        // Resolutions above ten act as ten.
        configure(11'd4, 4'd15);
        push_sample(10'd1023);
        push_sample(10'd0);
        push_sample(10'd1023);
        push_sample(10'd0);
        configure(11'd3, 4'd11);
        push_sample(10'd513);
        push_sample(10'd510);

        // Oversized and maximum lengths, each cut short by a later write.
        configure(11'd2047, 4'd10);
        push_sample(10'd5);
        push_sample(10'd1000);
        push_sample(10'd300);
        configure(11'd2, 4'd10);
        push_sample(10'd42);
        configure(FLEN_W'(MAX_FRAME_DEF), 4'd7);
        push_sample(10'd100);
        push_sample(10'd900);
        configure(11'd1, 4'd7);
        push_sample(10'd200);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = idle_send[ph];
            recv_idle_pct = idle_recv[ph];
            for (int s = 0; s < 10; s++) begin
                if ($urandom_range(0, 4) == 0)
                    configure(pick_frame_len(), RES_W'($urandom_range(0, 15)));
                else
                    configure(pick_frame_len(), RES_W'($urandom_range(1, 10)));
                for (int n = 0; n < 15; n++) begin
                    // Hold the sender until the output side has caught up.
                    if (n == 7 && (s == 0 || $urandom_range(0, 3) == 0))
                        wait_drain();
                    push_sample(pick_raw());
                end
            end
        end

        wait_drain();
        repeat (100) @(posedge i_clk);
        tracker.check_drained();
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
